FILE: design/blm_pkg.sv
// shared constants and types for the battery level monitor
`timescale 1ns / 1ps
package blm_pkg;

  localparam int unsigned VOLT_W = 16;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned ADC_W  = 15;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned NUM_W  = VOLT_W + PCT_W;

  typedef logic [1:0] level_t;

  localparam level_t LEVEL_NORMAL = 2'd0;
  localparam level_t LEVEL_WARN   = 2'd1;
  localparam level_t LEVEL_LOCK   = 2'd2;

  localparam logic [PCT_W-1:0]  PCT_FULL = 7'd100;
  localparam logic [VOLT_W-1:0] VOLT_MAX = 16'hFFFF;

  localparam logic [IDX_W-1:0] REG_EMPTY_LEVEL  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FULL_LEVEL   = 3'd1;
  localparam logic [IDX_W-1:0] REG_RISE_STEP    = 3'd2;
  localparam logic [IDX_W-1:0] REG_LOCK_LEVEL   = 3'd3;
  localparam logic [IDX_W-1:0] REG_WARN_LEVEL   = 3'd4;
  localparam logic [IDX_W-1:0] REG_WARN_PERIOD  = 3'd5;
  localparam logic [IDX_W-1:0] REG_DIODE_OFFSET = 3'd6;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

FILE: design/battery_level_monitor_unit.sv
// top level of the battery level monitor: scaling, update filter, level state and warn ticks
`timescale 1ns / 1ps
// Each transaction is either an ADC sample (func 0) or a loop tick (func 1) and yields
// exactly one result. A tick, a sample that is filtered out as a small rise, or a sample
// that lands at or beyond the empty or full level passes from the calc state straight to the
// output state. A sample between the empty and full levels runs the percent through the
// bit-serial divider, one quotient bit per cycle, via the start and divide states. One
// transaction is worked on at a time; a new one is accepted once the previous result is in
// the output register, even while that result still waits to be taken.
module battery_level_monitor_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [blm_pkg::ADC_W-1:0]     adc_reading_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [blm_pkg::VOLT_W-1:0]    voltage_now_o,
  output logic [blm_pkg::PCT_W-1:0]     percent_now_o,
  output logic [1:0]                    level_state_o,
  output logic                          warn_event_o,
  input  logic                          cfg_we_i,
  input  logic [blm_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [blm_pkg::VOLT_W-1:0]    cfg_data_i
);

  localparam int unsigned VW = blm_pkg::VOLT_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CALC  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_q, state_d;

  logic [VW-1:0] empty_q, full_q, step_q, lock_q, warn_q, period_q, offset_q;

  logic                      func_q;
  logic [blm_pkg::ADC_W-1:0] adc_q;

  logic [VW-1:0]             kept_volt_q, kept_volt_d;
  logic [blm_pkg::PCT_W-1:0] kept_pct_q, kept_pct_d;
  blm_pkg::level_t           kept_lvl_q, kept_lvl_d;
  blm_pkg::level_t           prev_lvl_q, prev_lvl_d;
  logic [VW-1:0]             countdown_q, countdown_d;
  logic                      ev_q, ev_d;
  logic [VW-1:0]             diff_q, diff_d;
  logic [VW-1:0]             den_q, den_d;

  logic                      out_valid_q, out_valid_d;
  logic [VW-1:0]             out_volt_q;
  logic [blm_pkg::PCT_W-1:0] out_pct_q;
  blm_pkg::level_t           out_lvl_q;
  logic                      out_ev_q;

  logic [VW+1:0]             sum;
  logic [VW-1:0]             volt;
  logic [VW-1:0]             rise;
  logic                      small_rise;
  logic [blm_pkg::NUM_W-1:0] num;
  logic                      out_free;
  logic                      load_out;
  logic                      div_start;
  logic                      div_done;
  logic [blm_pkg::PCT_W-1:0] div_quot;

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = (state_q == ST_OUT) && out_free;

  // reading times three plus the diode offset, saturated to 16 bits
  always_comb begin
    sum  = {3'b000, adc_q} + {2'b00, adc_q, 1'b0} + {2'b00, offset_q};
    volt = (sum[VW+1:VW] != 2'b00) ? blm_pkg::VOLT_MAX : sum[VW-1:0];
    rise = volt - kept_volt_q;
    small_rise = (volt > kept_volt_q) && (rise < step_q);
  end

  // diff times one hundred as 64 + 32 + 4
  assign num = {1'b0, diff_q, 6'b0} + {2'b00, diff_q, 5'b0} + {5'b0, diff_q, 2'b0};

  assign div_start = (state_q == ST_START);

  blm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    kept_volt_d = kept_volt_q;
    kept_pct_d  = kept_pct_q;
    kept_lvl_d  = kept_lvl_q;
    prev_lvl_d  = prev_lvl_q;
    countdown_d = countdown_q;
    ev_d        = ev_q;
    diff_d      = diff_q;
    den_d       = den_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        ev_d    = 1'b0;
        state_d = ST_OUT;
        if (func_q) begin
          if (kept_lvl_q == blm_pkg::LEVEL_WARN) begin
            if (prev_lvl_q != blm_pkg::LEVEL_WARN) begin
              countdown_d = '0;
            end else if (countdown_q <= VW'(1)) begin
              ev_d        = 1'b1;
              countdown_d = period_q;
            end else begin
              countdown_d = countdown_q - 1'b1;
            end
          end
          prev_lvl_d = kept_lvl_q;
        end else if (!small_rise) begin
          kept_volt_d = volt;
          if (volt < lock_q) begin
            kept_lvl_d = blm_pkg::LEVEL_LOCK;
          end else if (volt < warn_q) begin
            kept_lvl_d = blm_pkg::LEVEL_WARN;
          end else begin
            kept_lvl_d = blm_pkg::LEVEL_NORMAL;
          end
          if (volt <= empty_q) begin
            kept_pct_d = '0;
          end else if (volt >= full_q) begin
            kept_pct_d = blm_pkg::PCT_FULL;
          end else begin
            diff_d  = volt - empty_q;
            den_d   = full_q - empty_q;
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          kept_pct_d = div_quot;
          state_d    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      kept_volt_q <= '0;
      kept_pct_q  <= '0;
      kept_lvl_q  <= blm_pkg::LEVEL_NORMAL;
      prev_lvl_q  <= blm_pkg::LEVEL_NORMAL;
      countdown_q <= '0;
      ev_q        <= 1'b0;
      empty_q     <= 16'd3300;
      full_q      <= 16'd4200;
      step_q      <= 16'd50;
      lock_q      <= 16'd3400;
      warn_q      <= 16'd3500;
      period_q    <= 16'd6000;
      offset_q    <= 16'd300;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      kept_volt_q <= kept_volt_d;
      kept_pct_q  <= kept_pct_d;
      kept_lvl_q  <= kept_lvl_d;
      prev_lvl_q  <= prev_lvl_d;
      countdown_q <= countdown_d;
      ev_q        <= ev_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          blm_pkg::REG_EMPTY_LEVEL:  empty_q  <= cfg_data_i;
          blm_pkg::REG_FULL_LEVEL:   full_q   <= cfg_data_i;
          blm_pkg::REG_RISE_STEP:    step_q   <= cfg_data_i;
          blm_pkg::REG_LOCK_LEVEL:   lock_q   <= cfg_data_i;
          blm_pkg::REG_WARN_LEVEL:   warn_q   <= cfg_data_i;
          blm_pkg::REG_WARN_PERIOD:  period_q <= cfg_data_i;
          blm_pkg::REG_DIODE_OFFSET: offset_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    den_q  <= den_d;
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i;
      adc_q  <= adc_reading_i;
    end
    if (load_out) begin
      out_volt_q <= kept_volt_q;
      out_pct_q  <= kept_pct_q;
      out_lvl_q  <= kept_lvl_q;
      out_ev_q   <= ev_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign voltage_now_o = out_volt_q;
  assign percent_now_o = out_pct_q;
  assign level_state_o = out_lvl_q;
  assign warn_event_o  = out_ev_q;

endmodule

FILE: design/blm_div.sv
// bit-serial restoring divider producing the charge percent, one quotient bit per cycle
`timescale 1ns / 1ps
module blm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [blm_pkg::NUM_W-1:0]      num_i,
  input  logic [blm_pkg::VOLT_W-1:0]     den_i,
  output logic                           done_o,
  output logic [blm_pkg::PCT_W-1:0]      quot_o
);

  localparam int unsigned STEPS = blm_pkg::PCT_W;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [blm_pkg::VOLT_W-1:0]    rem_q, rem_d;
  logic [blm_pkg::VOLT_W-1:0]    den_q, den_d;
  logic [STEPS-1:0]              low_q, low_d;
  logic [STEPS-1:0]              quot_q, quot_d;
  logic [blm_pkg::VOLT_W:0]      shifted;
  logic [blm_pkg::VOLT_W+1:0]    trial;

  // quotient is below 2^STEPS, so the upper dividend bits already sit below the divisor
  always_comb begin
    shifted = {rem_q, low_q[STEPS-1]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    low_d   = low_q;
    quot_d  = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i[blm_pkg::NUM_W-1:STEPS];
      low_d  = num_i[STEPS-1:0];
      den_d  = den_i;
      quot_d = '0;
    end else if (busy_q) begin
      low_d = {low_q[STEPS-2:0], 1'b0};
      if (!trial[blm_pkg::VOLT_W+1]) begin
        rem_d  = trial[blm_pkg::VOLT_W-1:0];
        quot_d = {quot_q[STEPS-2:0], 1'b1};
      end else begin
        rem_d  = shifted[blm_pkg::VOLT_W-1:0];
        quot_d = {quot_q[STEPS-2:0], 1'b0};
      end
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
